// ===== rtl/core/lbre_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the line and box raster engine
package lbre_pkg;

  // default widths of coordinates and pixel colour
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_PIXEL_BITS = 8;

  // clip limit registers
  localparam int CLIP_BITS    = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CLIP_BITS-1:0] CLIP_X_RESET = 11'd447;
  localparam logic [CLIP_BITS-1:0] CLIP_Y_RESET = 11'd319;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_LINE    = 2'd1,
    KIND_BOX     = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIP_X = 2'd0,
    REG_CLIP_Y = 2'd1
  } cfg_reg_t;

  // classified commands handed to the back end
  typedef enum logic [1:0] {
    OP_ADVANCE    = 2'd0,
    OP_LINE       = 2'd1,
    OP_BOX        = 2'd2,
    OP_BOX_REJECT = 2'd3
  } cmd_op_t;

  // control part of a queued command
  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] step_down;  // bit0 x steps down, bit1 y steps down
    logic       x_major;
  } cmd_ctl_t;

endpackage

// ===== rtl/core/lbre_front.sv =====
`timescale 1ns / 1ps
// front end: clip registers, command classification and line/box setup
module lbre_front #(
  parameter int COORD_BITS = lbre_pkg::DEF_COORD_BITS,
  parameter int PIXEL_BITS = lbre_pkg::DEF_PIXEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lbre_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lbre_pkg::CLIP_BITS-1:0]       cfg_data,
  input  logic [1:0]                           in_kind,
  input  logic signed [COORD_BITS-1:0]         in_coord_xa,
  input  logic signed [COORD_BITS-1:0]         in_coord_ya,
  input  logic signed [COORD_BITS-1:0]         in_coord_xb,
  input  logic signed [COORD_BITS-1:0]         in_coord_yb,
  input  logic [PIXEL_BITS-1:0]                in_pixel_value,
  output logic                                 cmd_keep,
  output lbre_pkg::cmd_ctl_t                   cmd_ctl,
  output logic signed [COORD_BITS-1:0]         cmd_x0,
  output logic signed [COORD_BITS-1:0]         cmd_y0,
  output logic [COORD_BITS-1:0]                cmd_a,
  output logic [COORD_BITS-1:0]                cmd_b,
  output logic signed [COORD_BITS+2:0]         cmd_inc_a,
  output logic signed [COORD_BITS+2:0]         cmd_inc_b,
  output logic [PIXEL_BITS-1:0]                cmd_colour
);
  import lbre_pkg::*;

  localparam int DW       = COORD_BITS + 1;
  localparam int CMP_BITS = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;

  logic [CLIP_BITS-1:0] clip_x_r, clip_x_nxt;
  logic [CLIP_BITS-1:0] clip_y_r, clip_y_nxt;

  logic signed [DW-1:0]       diff_x, diff_y, neg_x, neg_y;
  logic                       x_up, y_up, x_maj;
  logic [COORD_BITS-1:0]      dx, dy, major, minor;
  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y, top_y;
  logic signed [CMP_BITS-1:0] lo_x_w, hi_x_w, lo_y_w, hi_y_w;
  logic signed [CMP_BITS-1:0] lim_x_w, lim_y_w, bot_w;
  logic                       box_reject;

  // configuration writes, accepted at any time
  assign cfg_ready = 1'b1;

  always_comb begin
    clip_x_nxt = clip_x_r;
    clip_y_nxt = clip_y_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CLIP_X: clip_x_nxt = cfg_data;
        REG_CLIP_Y: clip_y_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_x_r <= CLIP_X_RESET;
      clip_y_r <= CLIP_Y_RESET;
    end else begin
      clip_x_r <= clip_x_nxt;
      clip_y_r <= clip_y_nxt;
    end
  end

  // line setup: absolute deltas and major axis
  assign diff_x = DW'(in_coord_xb) - DW'(in_coord_xa);
  assign diff_y = DW'(in_coord_yb) - DW'(in_coord_ya);
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign x_up   = in_coord_xb > in_coord_xa;
  assign y_up   = in_coord_yb > in_coord_ya;
  assign dx     = x_up ? diff_x[COORD_BITS-1:0] : neg_x[COORD_BITS-1:0];
  assign dy     = y_up ? diff_y[COORD_BITS-1:0] : neg_y[COORD_BITS-1:0];
  assign x_maj  = dx >= dy;
  assign major  = x_maj ? dx : dy;
  assign minor  = x_maj ? dy : dx;

  // error increments: without and with the minor step
  assign cmd_inc_a = $signed({2'b00, minor, 1'b0});
  assign cmd_inc_b = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});

  // box setup: ordered corners, rejection and row clamp
  assign lo_x    = (in_coord_xa > in_coord_xb) ? in_coord_xb : in_coord_xa;
  assign hi_x    = (in_coord_xa > in_coord_xb) ? in_coord_xa : in_coord_xb;
  assign lo_y    = (in_coord_ya > in_coord_yb) ? in_coord_yb : in_coord_ya;
  assign hi_y    = (in_coord_ya > in_coord_yb) ? in_coord_ya : in_coord_yb;
  assign lo_x_w  = CMP_BITS'(lo_x);
  assign hi_x_w  = CMP_BITS'(hi_x);
  assign lo_y_w  = CMP_BITS'(lo_y);
  assign hi_y_w  = CMP_BITS'(hi_y);
  assign lim_x_w = CMP_BITS'($signed({1'b0, clip_x_r}));
  assign lim_y_w = CMP_BITS'($signed({1'b0, clip_y_r}));

  assign box_reject = (hi_x_w < 0) || (lo_x_w >= lim_x_w) ||
                      (hi_y_w < 0) || (lo_y_w >= lim_y_w);
  assign top_y = lo_y[COORD_BITS-1] ? '0 : lo_y;
  assign bot_w = (hi_y_w >= lim_y_w) ? (lim_y_w - CMP_BITS'(1)) : hi_y_w;

  // command word selection by kind
  always_comb begin
    cmd_keep          = 1'b1;
    cmd_ctl.op        = OP_ADVANCE;
    cmd_ctl.step_down = {!y_up, !x_up};
    cmd_ctl.x_major   = x_maj;
    cmd_x0            = in_coord_xa;
    cmd_y0            = in_coord_ya;
    cmd_a             = major;
    cmd_b             = minor;
    case (in_kind)
      KIND_ADVANCE: cmd_ctl.op = OP_ADVANCE;
      KIND_LINE:    cmd_ctl.op = OP_LINE;
      KIND_BOX: begin
        cmd_ctl.op = box_reject ? OP_BOX_REJECT : OP_BOX;
        cmd_x0     = lo_x;
        cmd_y0     = top_y;
        cmd_a      = hi_x;
        cmd_b      = bot_w[COORD_BITS-1:0];
      end
      default: cmd_keep = 1'b0;
    endcase
  end

  assign cmd_colour = in_pixel_value;

endmodule

// ===== rtl/core/lbre_queue.sv =====
`timescale 1ns / 1ps
// short command queue between the front and back ends
module lbre_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lbre_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import lbre_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/lbre_back.sv =====
`timescale 1ns / 1ps
// back end: drawing state, bresenham stepper, box row walker and output register
module lbre_back #(
  parameter int COORD_BITS = lbre_pkg::DEF_COORD_BITS,
  parameter int PIXEL_BITS = lbre_pkg::DEF_PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  lbre_pkg::cmd_ctl_t            cmd_ctl,
  input  logic signed [COORD_BITS-1:0]  cmd_x0,
  input  logic signed [COORD_BITS-1:0]  cmd_y0,
  input  logic [COORD_BITS-1:0]         cmd_a,
  input  logic [COORD_BITS-1:0]         cmd_b,
  input  logic signed [COORD_BITS+2:0]  cmd_inc_a,
  input  logic signed [COORD_BITS+2:0]  cmd_inc_b,
  input  logic [PIXEL_BITS-1:0]         cmd_colour,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_pixel_x,
  output logic signed [COORD_BITS-1:0]  out_pixel_y,
  output logic [PIXEL_BITS-1:0]         out_pixel_colour,
  output logic                          out_last_pixel
);
  import lbre_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int SW       = COORD_BITS + 1;

  // control state
  logic busy_r, busy_nxt;
  logic box_mode_r, box_mode_nxt;
  logic out_valid_r, out_valid_nxt;

  // drawing state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt;
  logic signed [ERR_BITS-1:0]   inc_a_r, inc_a_nxt;
  logic signed [ERR_BITS-1:0]   inc_b_r, inc_b_nxt;
  logic [SW-1:0]                steps_r, steps_nxt;
  logic [1:0]                   step_down_r, step_down_nxt;
  logic                         x_major_r, x_major_nxt;
  logic [PIXEL_BITS-1:0]        colour_r, colour_nxt;
  logic signed [COORD_BITS-1:0] row_left_r, row_left_nxt;
  logic signed [COORD_BITS-1:0] row_end_r, row_end_nxt;
  logic signed [COORD_BITS-1:0] bottom_r, bottom_nxt;

  // output register
  logic signed [COORD_BITS-1:0] px_r, px_nxt;
  logic signed [COORD_BITS-1:0] py_r, py_nxt;
  logic [PIXEL_BITS-1:0]        pc_r, pc_nxt;
  logic                         pl_r, pl_nxt;

  logic                         out_free, draws;
  logic signed [ERR_BITS-1:0]   err_a, err_b;
  logic                         minor_go, at_row_end, last;
  logic signed [COORD_BITS-1:0] x_step, y_step;

  // pop when the word makes no pixel or the output register can take one
  assign out_free = !out_valid_r || !out_stall;
  assign draws    = (cmd_ctl.op == OP_ADVANCE) && busy_r;
  assign cmd_pop  = cmd_valid && (!draws || out_free);

  // bresenham error candidates, both formed in parallel
  assign err_a    = err_r + inc_a_r;
  assign err_b    = err_r + inc_b_r;
  assign minor_go = !err_a[ERR_BITS-1];
  assign x_step   = step_down_r[0] ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
  assign y_step   = step_down_r[1] ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);

  // end of command detection
  assign at_row_end = cur_x_r == row_end_r;
  assign last = box_mode_r ? (at_row_end && (cur_y_r == bottom_r)) : (steps_r <= SW'(1));

  always_comb begin
    busy_nxt      = busy_r;
    box_mode_nxt  = box_mode_r;
    out_valid_nxt = out_valid_r && out_stall;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    inc_a_nxt     = inc_a_r;
    inc_b_nxt     = inc_b_r;
    steps_nxt     = steps_r;
    step_down_nxt = step_down_r;
    x_major_nxt   = x_major_r;
    colour_nxt    = colour_r;
    row_left_nxt  = row_left_r;
    row_end_nxt   = row_end_r;
    bottom_nxt    = bottom_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pc_nxt        = pc_r;
    pl_nxt        = pl_r;
    if (cmd_pop) begin
      case (cmd_ctl.op)
        OP_LINE: begin
          busy_nxt      = 1'b1;
          box_mode_nxt  = 1'b0;
          cur_x_nxt     = cmd_x0;
          cur_y_nxt     = cmd_y0;
          err_nxt       = ERR_BITS'(0) - ERR_BITS'(cmd_a);
          steps_nxt     = SW'(cmd_a) + SW'(1);
          inc_a_nxt     = cmd_inc_a;
          inc_b_nxt     = cmd_inc_b;
          step_down_nxt = cmd_ctl.step_down;
          x_major_nxt   = cmd_ctl.x_major;
          colour_nxt    = cmd_colour;
        end
        OP_BOX: begin
          busy_nxt     = 1'b1;
          box_mode_nxt = 1'b1;
          cur_x_nxt    = cmd_x0;
          cur_y_nxt    = cmd_y0;
          row_left_nxt = cmd_x0;
          row_end_nxt  = cmd_a;
          bottom_nxt   = cmd_b;
          colour_nxt   = cmd_colour;
        end
        OP_BOX_REJECT: begin
          busy_nxt   = 1'b0;
          colour_nxt = cmd_colour;
        end
        OP_ADVANCE: begin
          if (busy_r) begin
            out_valid_nxt = 1'b1;
            px_nxt        = cur_x_r;
            py_nxt        = cur_y_r;
            pc_nxt        = colour_r;
            pl_nxt        = last;
            if (box_mode_r) begin
              // walk a row left to right, then wrap to the next row
              if (at_row_end) begin
                cur_x_nxt = row_left_r;
                cur_y_nxt = cur_y_r + COORD_BITS'(1);
              end else begin
                cur_x_nxt = cur_x_r + COORD_BITS'(1);
              end
            end else begin
              // major axis always steps, minor axis when the error crosses zero
              if (x_major_r || minor_go) begin
                cur_x_nxt = x_step;
              end
              if (!x_major_r || minor_go) begin
                cur_y_nxt = y_step;
              end
              err_nxt = minor_go ? err_b : err_a;
              if (steps_r != '0) begin
                steps_nxt = steps_r - SW'(1);
              end
            end
            if (last) begin
              busy_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      box_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      box_mode_r  <= box_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    err_r       <= err_nxt;
    inc_a_r     <= inc_a_nxt;
    inc_b_r     <= inc_b_nxt;
    steps_r     <= steps_nxt;
    step_down_r <= step_down_nxt;
    x_major_r   <= x_major_nxt;
    colour_r    <= colour_nxt;
    row_left_r  <= row_left_nxt;
    row_end_r   <= row_end_nxt;
    bottom_r    <= bottom_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    pc_r        <= pc_nxt;
    pl_r        <= pl_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_pixel_colour = pc_r;
  assign out_last_pixel   = pl_r;

endmodule

// ===== rtl/core/line_and_box_raster_engine_top.sv =====
`timescale 1ns / 1ps
// top level of the line and box raster engine
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+------------------------------------------
//   in_     | input     | in_valid/in_stall   | kind, two corners, pixel value
//   out_    | output    | out_valid/out_stall | pixel x, pixel y, colour, last pixel flag
//   cfg_    | input     | cfg_valid/cfg_ready | register index, clip limit
//
// one input word per cycle while in_stall is low and one pixel per cycle while out_stall is low
// a pixel reaches out_ through the command queue and then the output register of the back end
// rst_n is synchronous: queue emptied, engine idle, clip limits back to 447 and 319
// out_stall holds the output register; in_stall rises only when the four-entry
// command queue is full
module line_and_box_raster_engine_top #(
  parameter int COORD_BITS = lbre_pkg::DEF_COORD_BITS,
  parameter int PIXEL_BITS = lbre_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbre_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lbre_pkg::CLIP_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic signed [COORD_BITS-1:0]      in_coord_xa,
  input  logic signed [COORD_BITS-1:0]      in_coord_ya,
  input  logic signed [COORD_BITS-1:0]      in_coord_xb,
  input  logic signed [COORD_BITS-1:0]      in_coord_yb,
  input  logic [PIXEL_BITS-1:0]             in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      out_pixel_x,
  output logic signed [COORD_BITS-1:0]      out_pixel_y,
  output logic [PIXEL_BITS-1:0]             out_pixel_colour,
  output logic                              out_last_pixel
);
  import lbre_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int CMD_W    = $bits(cmd_ctl_t) + 4 * COORD_BITS + 2 * ERR_BITS + PIXEL_BITS;

  // front end outputs
  logic                         f_keep;
  cmd_ctl_t                     f_ctl;
  logic signed [COORD_BITS-1:0] f_x0, f_y0;
  logic [COORD_BITS-1:0]        f_a, f_b;
  logic signed [ERR_BITS-1:0]   f_inc_a, f_inc_b;
  logic [PIXEL_BITS-1:0]        f_colour;

  // queue side
  logic             q_push, q_full, q_pop, q_valid;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // back end inputs
  cmd_ctl_t                     b_ctl;
  logic signed [COORD_BITS-1:0] b_x0, b_y0;
  logic [COORD_BITS-1:0]        b_a, b_b;
  logic signed [ERR_BITS-1:0]   b_inc_a, b_inc_b;
  logic [PIXEL_BITS-1:0]        b_colour;

  lbre_front #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_kind        (in_kind),
    .in_coord_xa    (in_coord_xa),
    .in_coord_ya    (in_coord_ya),
    .in_coord_xb    (in_coord_xb),
    .in_coord_yb    (in_coord_yb),
    .in_pixel_value (in_pixel_value),
    .cmd_keep       (f_keep),
    .cmd_ctl        (f_ctl),
    .cmd_x0         (f_x0),
    .cmd_y0         (f_y0),
    .cmd_a          (f_a),
    .cmd_b          (f_b),
    .cmd_inc_a      (f_inc_a),
    .cmd_inc_b      (f_inc_b),
    .cmd_colour     (f_colour)
  );

  // unused kind code is accepted and dropped here
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && f_keep;
  assign q_wdata  = {f_ctl, f_x0, f_y0, f_a, f_b, f_inc_a, f_inc_b, f_colour};

  lbre_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  assign {b_ctl, b_x0, b_y0, b_a, b_b, b_inc_a, b_inc_b, b_colour} = q_rdata;

  lbre_back #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_valid),
    .cmd_pop          (q_pop),
    .cmd_ctl          (b_ctl),
    .cmd_x0           (b_x0),
    .cmd_y0           (b_y0),
    .cmd_a            (b_a),
    .cmd_b            (b_b),
    .cmd_inc_a        (b_inc_a),
    .cmd_inc_b        (b_inc_b),
    .cmd_colour       (b_colour),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// ===== rtl/core/lbre_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the raster engine, bound to the top level
module lbre_checker #(
  parameter int COORD_BITS = lbre_pkg::DEF_COORD_BITS,
  parameter int PIXEL_BITS = lbre_pkg::DEF_PIXEL_BITS
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_pixel_x,
  input logic signed [COORD_BITS-1:0] out_pixel_y,
  input logic [PIXEL_BITS-1:0]        out_pixel_colour,
  input logic                         out_last_pixel
);
  import lbre_pkg::*;

  // reset leaves no pixel pending and the queue open
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output word or input stall survived reset");

  // a stalled pixel holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_colour) && $stable(out_last_pixel))
    else $error("stalled output word changed");

  // a full queue drains whenever the output side can move
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && (!out_valid || !out_stall) |=> !in_stall)
    else $error("input stall held while back end was free to pop");

  // input stall rises only after a stalled pixel or an input word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall) || $past(in_valid))
    else $error("input stall rose without traffic");

endmodule

bind line_and_box_raster_engine_top lbre_checker #(
  .COORD_BITS (COORD_BITS),
  .PIXEL_BITS (PIXEL_BITS)
) u_lbre_checker (.*);
